FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms, reset-gated or not, shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert prop at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// assert prop at every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/ccg_pkg.sv
// ----------------------------------------------------------------------------
// ccg_pkg
// Widths, register codes and gradient tables of the color cycle gradient.
// ----------------------------------------------------------------------------
package ccg_pkg;

	localparam int FRAME_W  = 32;
	localparam int COLOR_W  = 32;
	localparam int PERIOD_W = 16;
	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 2;
	localparam int SEG_W    = 3;
	localparam int DIV_W    = 19;
	localparam int PROD_W   = PERIOD_W + 8;
	localparam int CH_W     = 8;
	localparam int NCH      = 4;
	localparam int DIV_STEPS  = FRAME_W;
	localparam int QUOT_STEPS = CH_W;
	localparam int LATENCY    = DIV_STEPS + QUOT_STEPS + 4;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [SEG_W-1:0]    seg_t;
	typedef logic [NCH-1:0]      chmask_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_CYCLE_MODE     = 2'd0,
		REG_SEGMENT_PERIOD = 2'd1
	} reg_index_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_THREE_HUE = 2'd0,
		MODE_RAINBOW   = 2'd1,
		MODE_PULSE     = 2'd2,
		MODE_RAINBOW_B = 2'd3
	} mode_code_t;

	localparam mode_t   CYCLE_MODE_RST     = MODE_RAINBOW;
	localparam period_t SEGMENT_PERIOD_RST = 16'd100;

	// channel masks: bit 3 alpha, bit 2 red, bit 1 green, bit 0 blue
	localparam chmask_t THREE_FROM [3] = '{4'b1101, 4'b1110, 4'b1011};
	localparam chmask_t THREE_TO   [3] = '{4'b1011, 4'b1101, 4'b1110};
	localparam chmask_t RAIN_FROM  [6] = '{4'b1001, 4'b1011, 4'b1010,
	                                       4'b1110, 4'b1100, 4'b1101};
	localparam chmask_t RAIN_TO    [6] = '{4'b1011, 4'b1010, 4'b1110,
	                                       4'b1100, 4'b1101, 4'b1001};
	localparam chmask_t PULSE_FROM [2] = '{4'b1111, 4'b1000};
	localparam chmask_t PULSE_TO   [2] = '{4'b1000, 4'b1111};

	function automatic seg_t seg_count(mode_t mode);
		unique case (mode)
			MODE_THREE_HUE: seg_count = 3'd3;
			MODE_PULSE:     seg_count = 3'd2;
			default:        seg_count = 3'd6;
		endcase
	endfunction

	function automatic chmask_t grad_mask(mode_t mode, seg_t seg, logic to_side);
		chmask_t m;
		m = '0;
		unique case (mode)
			MODE_THREE_HUE: begin
				if (seg < 3'd3) m = to_side ? THREE_TO[seg[1:0]] : THREE_FROM[seg[1:0]];
			end
			MODE_PULSE: begin
				if (seg < 3'd2) m = to_side ? PULSE_TO[seg[0]] : PULSE_FROM[seg[0]];
			end
			default: begin
				if (seg < 3'd6) m = to_side ? RAIN_TO[seg] : RAIN_FROM[seg];
			end
		endcase
		return m;
	endfunction

endpackage

FILE: src/color_cycle_gradient.sv
// ----------------------------------------------------------------------------
// color_cycle_gradient
// Maps a frame count to an ARGB color blended along a cyclic gradient.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low and results never stall.
// Latency is set by the 32 bit-serial stages of the cycle-position remainder
// plus 8 stages of the blend-weight quotient.
// Reset clears all valid bits and loads cycle_mode 1 and segment_period 100.
module color_cycle_gradient (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ccg_pkg::FRAME_W-1:0]   frame_count,
	output logic                          done,
	output logic [ccg_pkg::COLOR_W-1:0]   color_out,
	input  logic                          cfg_we,
	input  logic [ccg_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [ccg_pkg::PERIOD_W-1:0]  cfg_wdata
);

`include "assert_macros.svh"

	localparam int DS = ccg_pkg::DIV_STEPS;
	localparam int QS = ccg_pkg::QUOT_STEPS;
	localparam int DW = ccg_pkg::DIV_W;
	localparam int PW = ccg_pkg::PERIOD_W;

	ccg_pkg::mode_t   cycle_mode_q;
	ccg_pkg::period_t segment_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_mode_q     <= ccg_pkg::CYCLE_MODE_RST;
			segment_period_q <= ccg_pkg::SEGMENT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccg_pkg::REG_CYCLE_MODE:     cycle_mode_q <= cfg_wdata[ccg_pkg::MODE_W-1:0];
				ccg_pkg::REG_SEGMENT_PERIOD: segment_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// derived divisors
	ccg_pkg::period_t t_eff;
	logic [DW-1:0]    t1, t2, t3, t4, t5, cyc_len;
	ccg_pkg::seg_t    nseg;

	assign t_eff = (segment_period_q == '0) ? PW'(1) : segment_period_q;
	assign t1    = DW'(t_eff);
	assign t2    = t1 << 1;
	assign t3    = t1 + t2;
	assign t4    = t1 << 2;
	assign t5    = t4 + t1;
	assign nseg  = ccg_pkg::seg_count(cycle_mode_q);

	always_comb begin
		unique case (nseg)
			3'd2:    cyc_len = t2;
			3'd3:    cyc_len = t3;
			default: cyc_len = t3 << 1;
		endcase
	end

	assign busy = 1'b0;

	// frame_count mod cycle length, one bit per stage
	logic                        dvld_s [DS+1];
	logic [DW-1:0]               drem_s [DS+1];
	logic [ccg_pkg::FRAME_W-1:0] ddvd_s [DS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvld_s[0] <= 1'b0;
		else         dvld_s[0] <= start && !busy;
	end

	always_ff @(posedge clk) begin
		ddvd_s[0] <= frame_count;
		drem_s[0] <= '0;
	end

	for (genvar k = 1; k <= DS; k++) begin : g_div
		logic [DW:0] trial;
		logic        ge;

		assign trial = {drem_s[k-1], ddvd_s[k-1][ccg_pkg::FRAME_W-1]};
		assign ge    = trial >= {1'b0, cyc_len};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvld_s[k] <= 1'b0;
			else         dvld_s[k] <= dvld_s[k-1];
		end

		always_ff @(posedge clk) begin
			drem_s[k] <= ge ? DW'(trial - {1'b0, cyc_len}) : DW'(trial);
			ddvd_s[k] <= ddvd_s[k-1] << 1;
		end
	end

	// segment select and offset within segment
	logic [DW-1:0]    x;
	ccg_pkg::seg_t    seg_c;
	logic [DW-1:0]    base_c;
	logic             vld_s34;
	ccg_pkg::seg_t    seg_s34;
	ccg_pkg::period_t m_s34;

	assign x = drem_s[DS];

	always_comb begin
		priority if (x >= t5) begin
			seg_c = 3'd5; base_c = t5;
		end else if (x >= t4) begin
			seg_c = 3'd4; base_c = t4;
		end else if (x >= t3) begin
			seg_c = 3'd3; base_c = t3;
		end else if (x >= t2) begin
			seg_c = 3'd2; base_c = t2;
		end else if (x >= t1) begin
			seg_c = 3'd1; base_c = t1;
		end else begin
			seg_c = 3'd0; base_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s34 <= 1'b0;
		else         vld_s34 <= dvld_s[DS];
	end

	always_ff @(posedge clk) begin
		seg_s34 <= seg_c;
		m_s34   <= PW'(x - base_c);
	end

	// 255 * m / T, one quotient bit per stage
	logic                  qvld_s [QS+1];
	ccg_pkg::seg_t         qseg_s [QS+1];
	logic [PW-1:0]         qrem_s [QS+1];
	logic [QS-1:0]         qlow_s [QS+1];
	logic [QS-1:0]         qquo_s [QS+1];
	logic [ccg_pkg::PROD_W-1:0] prod;

	assign prod = {m_s34, 8'd0} - ccg_pkg::PROD_W'(m_s34);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qvld_s[0] <= 1'b0;
		else         qvld_s[0] <= vld_s34;
	end

	always_ff @(posedge clk) begin
		qseg_s[0] <= seg_s34;
		qrem_s[0] <= prod[ccg_pkg::PROD_W-1:QS];
		qlow_s[0] <= prod[QS-1:0];
		qquo_s[0] <= '0;
	end

	for (genvar k = 1; k <= QS; k++) begin : g_quot
		logic [PW:0] trial;
		logic        ge;

		assign trial = {qrem_s[k-1], qlow_s[k-1][QS-1]};
		assign ge    = trial >= {1'b0, t_eff};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qvld_s[k] <= 1'b0;
			else         qvld_s[k] <= qvld_s[k-1];
		end

		always_ff @(posedge clk) begin
			qseg_s[k] <= qseg_s[k-1];
			qrem_s[k] <= ge ? PW'(trial - {1'b0, t_eff}) : PW'(trial);
			qlow_s[k] <= qlow_s[k-1] << 1;
			qquo_s[k] <= {qquo_s[k-1][QS-2:0], ge};
		end
	end

	// blend channels
	logic [QS:0]      ceil_w;
	logic [QS-1:0]    inv_w;
	logic [QS-1:0]    quo;
	ccg_pkg::chmask_t from_m, to_m;
	logic [ccg_pkg::COLOR_W-1:0] color_c;

	assign quo    = qquo_s[QS];
	assign ceil_w = {1'b0, quo} + (QS+1)'(qrem_s[QS] != '0);
	assign inv_w  = QS'((QS+1)'(255) - ceil_w);
	assign from_m = ccg_pkg::grad_mask(cycle_mode_q, qseg_s[QS], 1'b0);
	assign to_m   = ccg_pkg::grad_mask(cycle_mode_q, qseg_s[QS], 1'b1);

	always_comb begin
		for (int c = 0; c < ccg_pkg::NCH; c++) begin
			color_c[c*ccg_pkg::CH_W +: ccg_pkg::CH_W] =
				(from_m[c] ? inv_w : '0) + (to_m[c] ? quo : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= qvld_s[QS];
	end

	always_ff @(posedge clk) begin
		color_out <= color_c;
	end

	`ASSERT_CLK(a_latency, start && !busy |-> ##(ccg_pkg::LATENCY) done, "item result missing")
	`ASSERT_CLK(a_no_phantom, done |-> $past(start && !busy, ccg_pkg::LATENCY), "result without item")
	`ASSERT_CLK(a_mid_pipe, vld_s34 |-> ##(QS+2) done, "item lost after segment select")
	`ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

FILE: tb/gradient_color_checker.sv
// ----------------------------------------------------------------------------
// gradient_color_checker
// Tracks the register writes, computes the color expected for every
// accepted frame count and compares each result strobe, in order, against
// the oldest color still outstanding.
// ----------------------------------------------------------------------------
module gradient_color_checker
	import ccg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [FRAME_W-1:0]  frame_count,
	input  logic                done,
	input  logic [COLOR_W-1:0]  color_out,
	input  logic                cfg_we,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [PERIOD_W-1:0] cfg_wdata,
	output int                  fail_count,
	output int                  pending,
	output int                  checked
);

	localparam logic [COLOR_W-1:0] MAGENTA = 32'hffff00ff;
	localparam logic [COLOR_W-1:0] CYAN    = 32'hff00ffff;
	localparam logic [COLOR_W-1:0] YELLOW  = 32'hffffff00;
	localparam logic [COLOR_W-1:0] BLUE    = 32'hff0000ff;
	localparam logic [COLOR_W-1:0] GREEN   = 32'hff00ff00;
	localparam logic [COLOR_W-1:0] RED     = 32'hffff0000;
	localparam logic [COLOR_W-1:0] WHITE   = 32'hffffffff;
	localparam logic [COLOR_W-1:0] BLACK   = 32'hff000000;

	localparam logic [COLOR_W-1:0] THREE_START [3] = '{MAGENTA, YELLOW, CYAN};
	localparam logic [COLOR_W-1:0] THREE_END   [3] = '{CYAN, MAGENTA, YELLOW};
	localparam logic [COLOR_W-1:0] RAIN_START  [6] = '{BLUE, CYAN, GREEN, YELLOW, RED, MAGENTA};
	localparam logic [COLOR_W-1:0] RAIN_END    [6] = '{CYAN, GREEN, YELLOW, RED, MAGENTA, BLUE};
	localparam logic [COLOR_W-1:0] PULSE_START [2] = '{WHITE, BLACK};
	localparam logic [COLOR_W-1:0] PULSE_END   [2] = '{BLACK, WHITE};

	mode_t              mode_q;
	period_t            period_q;
	logic [COLOR_W-1:0] expected_colors [$];
	logic [COLOR_W-1:0] want_color;
	int                 fails = 0;
	int                 compared = 0;

	function automatic logic [COLOR_W-1:0] gradient_color(logic [FRAME_W-1:0] frame,
		mode_t mode, period_t period);
		int unsigned        t, segs, x, seg, m, ca, cb, ch;
		int                 k;
		logic [COLOR_W-1:0] c_start, c_end, color;
		t = (period == '0) ? 32'd1 : 32'(period);
		case (mode)
			MODE_THREE_HUE: segs = 3;
			MODE_PULSE:     segs = 2;
			default:        segs = 6;
		endcase
		x = frame % (t * segs);
		seg = x / t;
		m = x % t;
		case (mode)
			MODE_THREE_HUE: begin
				c_start = THREE_START[seg];
				c_end = THREE_END[seg];
			end
			MODE_PULSE: begin
				c_start = PULSE_START[seg];
				c_end = PULSE_END[seg];
			end
			default: begin
				c_start = RAIN_START[seg];
				c_end = RAIN_END[seg];
			end
		endcase
		color = '0;
		for (k = 0; k < NCH; k++) begin
			ca = 32'(c_start[CH_W*k +: CH_W]);
			cb = 32'(c_end[CH_W*k +: CH_W]);
			ch = ca * (t - m) / t + cb * m / t;
			color[CH_W*k +: CH_W] = CH_W'(ch);
		end
		return color;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= CYCLE_MODE_RST;
			period_q <= SEGMENT_PERIOD_RST;
			expected_colors.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CYCLE_MODE:     mode_q <= cfg_wdata[MODE_W-1:0];
					REG_SEGMENT_PERIOD: period_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_colors.push_back(gradient_color(frame_count, mode_q, period_q));
			if (done) begin
				compared++;
				if (expected_colors.size() == 0) begin
					fails++;
					$error("color_out: result with no item waiting, actual %08h", color_out);
				end else begin
					want_color = expected_colors.pop_front();
					if (color_out !== want_color) begin
						fails++;
						$error("color_out: expected %08h, actual %08h", want_color, color_out);
					end
				end
			end
			pending <= expected_colors.size();
			fail_count <= fails;
			checked <= compared;
		end
	end

endmodule

FILE: tb/color_cycle_gradient_tb.sv
// ----------------------------------------------------------------------------
// color_cycle_gradient_tb
// Drives frame counts and register writes into the gradient block: a short
// directed pass over period and frame extremes, every mode and ignored
// register writes, then random phases under random settings. A checker
// beside the block predicts and compares every color.
// ----------------------------------------------------------------------------
module color_cycle_gradient_tb;
	import ccg_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 100;
	localparam int IDLE_PERCENT  = 20;

	localparam logic [INDEX_W-1:0] UNUSED_INDEX_LO = 2'd2;
	localparam logic [INDEX_W-1:0] UNUSED_INDEX_HI = 2'd3;

	localparam logic [FRAME_W-1:0] RESET_FRAMES   [6] = '{32'd0, 32'd99, 32'd100, 32'd599,
	                                                      32'd600, 32'hffffffff};
	localparam logic [FRAME_W-1:0] FAST_FRAMES    [5] = '{32'd0, 32'd1, 32'd2, 32'd3,
	                                                      32'hffffffff};
	localparam logic [FRAME_W-1:0] SLOW_FRAMES    [5] = '{32'd0, 32'd65534, 32'd65535,
	                                                      32'd131069, 32'hffffffff};
	localparam logic [FRAME_W-1:0] ZERO_FRAMES    [3] = '{32'd0, 32'd5, 32'hffffffff};
	localparam logic [FRAME_W-1:0] IGNORED_FRAMES [3] = '{32'd41, 32'd42, 32'h7fffffff};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FRAME_W-1:0]  frame_count;
	logic                done;
	logic [COLOR_W-1:0]  color_out;
	logic                cfg_we;
	logic [INDEX_W-1:0]  cfg_index;
	logic [PERIOD_W-1:0] cfg_wdata;

	int                  fail_count;
	int                  pending;
	int                  checked;
	int                  frames_sent = 0;
	int                  settings_used = 1;
	int                  stall_cycles;
	bit                  idle_on = 1'b1;
	int unsigned         cur_t = 100;
	int unsigned         cur_segs = 6;
	logic [NCH-1:0]      modes_seen = '0;
	logic [FRAME_W-1:0]  last_frame = '0;

	color_cycle_gradient dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.frame_count(frame_count),
		.done       (done),
		.color_out  (color_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	gradient_color_checker color_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.frame_count(frame_count),
		.done       (done),
		.color_out  (color_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_frame(input logic [FRAME_W-1:0] frame);
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		frame_count <= frame;
		do @(posedge clk); while (busy !== 1'b0);
		frames_sent++;
		last_frame = frame;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_register(input logic [INDEX_W-1:0] index,
		input logic [PERIOD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [PERIOD_W-1:0] mode_word,
		input logic [PERIOD_W-1:0] period, input bit with_junk);
		mode_t mode;
		start <= 1'b0;
		wait_idle();
		write_register(REG_CYCLE_MODE, mode_word);
		write_register(REG_SEGMENT_PERIOD, period);
		if (with_junk) begin
			write_register(UNUSED_INDEX_LO, PERIOD_W'($urandom));
			write_register(UNUSED_INDEX_HI, PERIOD_W'($urandom));
		end
		cfg_we <= 1'b0;
		mode = mode_word[MODE_W-1:0];
		modes_seen[mode] = 1'b1;
		cur_t = (period == '0) ? 32'd1 : 32'(period);
		cur_segs = (mode == MODE_THREE_HUE) ? 3 : (mode == MODE_PULSE) ? 2 : 6;
		settings_used++;
	endtask

	initial begin
		int unsigned         r, span, offset;
		int                  quiet_phase;
		logic [PERIOD_W-1:0] period;
		logic [FRAME_W-1:0]  frame;

		arst_n <= 1'b0;
		start <= 1'b0;
		frame_count <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		modes_seen[CYCLE_MODE_RST] = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (RESET_FRAMES[i]) send_frame(RESET_FRAMES[i]);
		reconfigure(PERIOD_W'(MODE_THREE_HUE), 16'd1, 1'b0);
		foreach (FAST_FRAMES[i]) send_frame(FAST_FRAMES[i]);
		reconfigure(PERIOD_W'(MODE_PULSE), 16'hffff, 1'b0);
		foreach (SLOW_FRAMES[i]) send_frame(SLOW_FRAMES[i]);
		reconfigure(PERIOD_W'(MODE_RAINBOW_B), 16'd0, 1'b0);
		foreach (ZERO_FRAMES[i]) send_frame(ZERO_FRAMES[i]);
		reconfigure(PERIOD_W'(MODE_RAINBOW), 16'd7, 1'b1);
		foreach (IGNORED_FRAMES[i]) send_frame(IGNORED_FRAMES[i]);

		quiet_phase = $urandom_range(0, RANDOM_PHASES - 1);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				period = PERIOD_W'($urandom_range(1, 16));
			else if (r < 65)
				period = PERIOD_W'($urandom_range(17, 1000));
			else if (r < 85)
				period = PERIOD_W'($urandom_range(0, 65535));
			else if (r < 92)
				period = '0;
			else
				period = '1;
			reconfigure(PERIOD_W'($urandom), period, $urandom_range(0, 3) == 0);
			idle_on = (p != quiet_phase);
			span = cur_t * cur_segs;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					frame = $urandom();
				end else if (r < 55) begin
					r = $urandom_range(0, 3);
					if (r == 0)
						offset = 0;
					else if (r == 1)
						offset = 1;
					else if (r == 2)
						offset = cur_t - 1;
					else
						offset = $urandom_range(0, cur_t - 1);
					frame = span * $urandom_range(0, 4000)
						+ cur_t * $urandom_range(0, cur_segs - 1) + offset;
				end else if (r < 70) begin
					frame = $urandom_range(0, 3 * span - 1);
				end else if (r < 80) begin
					frame = 32'hffffffff - $urandom_range(0, 2 * span);
				end else begin
					frame = last_frame + 1;
				end
				send_frame(frame);
			end
		end

		start <= 1'b0;
		wait_idle();
		repeat (LATENCY + 8) @(posedge clk);
		$display("Sent %0d frame counts, checked %0d colors, over %0d register settings.",
			frames_sent, checked, settings_used);
		$display("Modes exercised (mask by code) %b, periods 0 through 65535.", modes_seen);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$error("watchdog: nothing accepted for %0d cycles, %0d colors outstanding",
			STALL_LIMIT, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
